FILE: rtl/core/ribsm_pkg.sv
// ----------------------------------------------------------------------------
// Range interleaved bank/set mapper package
// Shared widths, status codes, CSR indices and the divider request and response types.
// ----------------------------------------------------------------------------
package ribsm_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int ADDR_BITS     = 48;
   localparam int IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);
   localparam int DIV_BITS      = 64;
   localparam int DIV_CNT_BITS  = $clog2(DIV_BITS + 1);

   localparam int REQ_DATA_BITS = 160; // 48+48+32+12+20 = 160
   localparam int RSP_DATA_BITS = 40;  // 3+12+20 = 35 -> 40

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_MISS    = 3'd1,
      ST_OVERLAP = 3'd2,
      ST_FULL    = 3'd3,
      ST_ZERO_IL = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_ROWS  = 2'd0,
      CSR_COLS  = 2'd1,
      CSR_LINE  = 2'd2,
      CSR_SETS  = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] dividend;
      logic [DIV_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quotient;
      logic [DIV_BITS-1:0] remainder;
   } div_rsp_type;

endpackage

FILE: rtl/core/ribsm_divider.sv
// ----------------------------------------------------------------------------
// Range mapper divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ribsm_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  ribsm_pkg::div_req_type req,
   output ribsm_pkg::div_rsp_type rsp
);
   import ribsm_pkg::*;

   logic                    busy_ff, busy_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DIV_BITS-1:0]     quo_ff, quo_in;
   logic [DIV_BITS-1:0]     rem_ff, rem_in;
   logic [DIV_BITS-1:0]     dvs_ff, dvs_in;
   logic                    done_ff, done_in;
   logic [DIV_BITS:0]       trial;
   logic [DIV_BITS:0]       shifted;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[DIV_BITS-1]};
      trial   = shifted - {1'b0, dvs_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_BITS'(DIV_BITS);
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         // shift in next dividend bit, subtract when it fits
         if (!trial[DIV_BITS]) begin
            rem_in = trial[DIV_BITS-1:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_BITS-1:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_BITS'(1);
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

FILE: rtl/core/ribsm_table.sv
// ----------------------------------------------------------------------------
// Range mapper table
// Range entries with valid bits; one entry read per cycle at a chosen slot.
// ----------------------------------------------------------------------------
module ribsm_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ribsm_pkg::IDX_BITS-1:0] rd_idx,
   output logic                          rd_valid,
   output logic [ribsm_pkg::ADDR_BITS-1:0] rd_start,
   output logic [ribsm_pkg::ADDR_BITS-1:0] rd_end,
   output logic [31:0]                   rd_il,
   output logic [11:0]                   rd_bank,
   output logic [19:0]                   rd_set,
   input  logic                          wr_en,
   input  logic [ribsm_pkg::IDX_BITS-1:0] wr_idx,
   input  logic [ribsm_pkg::ADDR_BITS-1:0] wr_start,
   input  logic [ribsm_pkg::ADDR_BITS-1:0] wr_end,
   input  logic [31:0]                   wr_il,
   input  logic [11:0]                   wr_bank,
   input  logic [19:0]                   wr_set
);
   import ribsm_pkg::*;

   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [ADDR_BITS-1:0]     start_mem [TABLE_ENTRIES];
   logic [ADDR_BITS-1:0]     end_mem   [TABLE_ENTRIES];
   logic [31:0]              il_mem    [TABLE_ENTRIES];
   logic [11:0]              bank_mem  [TABLE_ENTRIES];
   logic [19:0]              set_mem   [TABLE_ENTRIES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
      if (wr_en) begin
         start_mem[wr_idx] <= wr_start;
         end_mem[wr_idx]   <= wr_end;
         il_mem[wr_idx]    <= wr_il;
         bank_mem[wr_idx]  <= wr_bank;
         set_mem[wr_idx]   <= wr_set;
      end
   end

   assign rd_valid = valid_ff[rd_idx];
   assign rd_start = start_mem[rd_idx];
   assign rd_end   = end_mem[rd_idx];
   assign rd_il    = il_mem[rd_idx];
   assign rd_bank  = bank_mem[rd_idx];
   assign rd_set   = set_mem[rd_idx];

endmodule

FILE: rtl/core/range_interleaved_bank_set_mapper_unit.sv
// ----------------------------------------------------------------------------
// Range interleaved bank/set mapper
// Sequencer that scans the range table and maps through a shared divider.
// ----------------------------------------------------------------------------
// One word in, one word out. An insert scans the TABLE_ENTRIES slots, one per
// cycle, stops early on an overlap, and writes the first free slot. A miss
// scans every slot. A hit runs six divisions on the one shared bit-serial
// divider and a shift-add multiply. The unit takes no new word until the
// result word has been taken.
module range_interleaved_bank_set_mapper_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ribsm_pkg::REQ_DATA_BITS-1:0] req_tdata,   // address, end_address, interleave, start_bank, start_set
   input  logic                                req_tuser,   // kind
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ribsm_pkg::RSP_DATA_BITS-1:0] rsp_tdata,   // status, bank, set_index, zero fill
   input  logic                                csr_we,
   input  logic [1:0]                          csr_index,
   input  logic [20:0]                         csr_wdata
);
   import ribsm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_INS, S_D1, S_D2, S_D3, S_MUL, S_D4, S_D5, S_D6, S_RSP
   } state_type;

   state_type             state_ff;
   logic [6:0]            rows_ff, cols_ff;
   logic [12:0]           line_ff;
   logic [20:0]           sets_ff;
   logic                  kind_ff;
   logic [ADDR_BITS-1:0]  a_ff, b_ff;
   logic [31:0]           il_ff;
   logic [11:0]           fb_ff;
   logic [19:0]           fs_ff;
   logic [CNT_BITS-1:0]   idx_ff;
   logic                  free_ok_ff;
   logic [IDX_BITS-1:0]   free_ff;
   logic                  div_wait_ff;
   logic [DIV_BITS-1:0]   t1_ff, t2_ff, t3_ff;
   logic [DIV_BITS-1:0]   prod_ff;
   logic [2:0]            st_ff;
   logic [11:0]           bank_ff;
   logic [19:0]           set_ff;

   logic [6:0]            rows_c, cols_c;
   logic [12:0]           line_c;
   logic [20:0]           sets_c;
   logic [12:0]           banks;
   logic [IDX_BITS-1:0]   rd_idx;
   logic                  rd_valid;
   logic [ADDR_BITS-1:0]  rd_start, rd_end;
   logic [31:0]           rd_il;
   logic [11:0]           rd_bank;
   logic [19:0]           rd_set;
   logic                  wr_en;
   div_req_type           dreq;
   div_rsp_type           drsp;
   logic [DIV_BITS-1:0]   d;

   always_comb begin
      rows_c = (rows_ff == 7'd0) ? 7'd1 : (rows_ff > 7'd64 ? 7'd64 : rows_ff);
      cols_c = (cols_ff == 7'd0) ? 7'd1 : (cols_ff > 7'd64 ? 7'd64 : cols_ff);
      line_c = (line_ff == 13'd0) ? 13'd1 : (line_ff > 13'd4096 ? 13'd4096 : line_ff);
      sets_c = (sets_ff == 21'd0) ? 21'd1 : (sets_ff > 21'd1048576 ? 21'd1048576 : sets_ff);
      banks  = 13'(rows_c) * 13'(cols_c);
   end

   assign rd_idx = idx_ff[IDX_BITS-1:0];
   assign wr_en  = (state_ff == S_INS) && free_ok_ff;
   assign d      = DIV_BITS'(a_ff - b_ff); // b holds entry start on lookup

   ribsm_table u_table (
      .clock, .reset, .rd_idx, .rd_valid, .rd_start, .rd_end, .rd_il, .rd_bank,
      .rd_set, .wr_en, .wr_idx(free_ff), .wr_start(a_ff), .wr_end(b_ff),
      .wr_il(il_ff), .wr_bank(fb_ff), .wr_set(fs_ff)
   );

   ribsm_divider u_div (.clock, .reset, .req(dreq), .rsp(drsp));

   // divider launch: operands per step
   always_comb begin
      dreq = '0;
      if (!div_wait_ff) begin
         unique case (state_ff)
            S_D1: begin
               dreq = '{1'b1, d, DIV_BITS'(il_ff)};
            end
            S_D2: begin
               dreq = '{1'b1, DIV_BITS'(fb_ff) + t1_ff, DIV_BITS'(banks)};
            end
            S_D3: begin
               dreq = '{1'b1, d, DIV_BITS'(il_ff) * DIV_BITS'(banks)};
            end
            S_D4: begin
               dreq = '{1'b1, DIV_BITS'(il_ff), DIV_BITS'(line_c)};
            end
            S_D5: begin
               dreq = '{1'b1, t2_ff, DIV_BITS'(line_c)};
            end
            S_D6: begin
               dreq = '{1'b1, t3_ff + DIV_BITS'(fs_ff), DIV_BITS'(sets_c)};
            end
            default: dreq = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rows_ff     <= 7'd8;
         cols_ff     <= 7'd8;
         line_ff     <= 13'd64;
         sets_ff     <= 21'd1024;
         div_wait_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_ROWS: rows_ff <= csr_wdata[6:0];
               CSR_COLS: cols_ff <= csr_wdata[6:0];
               CSR_LINE: line_ff <= csr_wdata[12:0];
               CSR_SETS: sets_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (drsp.done)      div_wait_ff <= 1'b0;
         else if (dreq.start) div_wait_ff <= 1'b1;
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  kind_ff    <= req_tuser;
                  a_ff       <= req_tdata[47:0];
                  b_ff       <= req_tdata[95:48];
                  il_ff      <= req_tdata[127:96];
                  fb_ff      <= req_tdata[139:128];
                  fs_ff      <= req_tdata[159:140];
                  idx_ff     <= '0;
                  free_ok_ff <= 1'b0;
                  bank_ff    <= '0;
                  set_ff     <= '0;
                  if (!req_tuser && req_tdata[127:96] == 32'd0) begin
                     st_ff    <= ST_ZERO_IL;
                     state_ff <= S_RSP;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (idx_ff == CNT_BITS'(TABLE_ENTRIES)) begin
                  if (kind_ff) begin
                     st_ff    <= ST_MISS;
                     state_ff <= S_RSP;
                  end else if (free_ok_ff) begin
                     st_ff    <= ST_OK;
                     state_ff <= S_INS;
                  end else begin
                     st_ff    <= ST_FULL;
                     state_ff <= S_RSP;
                  end
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  if (!kind_ff) begin
                     if (!rd_valid) begin
                        if (!free_ok_ff) begin
                           free_ok_ff <= 1'b1;
                           free_ff    <= rd_idx;
                        end
                     end else if (!(rd_start >= b_ff || rd_end <= a_ff)) begin
                        st_ff    <= ST_OVERLAP;
                        state_ff <= S_RSP;
                     end
                  end else if (rd_valid && rd_start <= a_ff && a_ff < rd_end) begin
                     // hold entry fields for the mapping steps
                     b_ff     <= rd_start;
                     il_ff    <= (rd_il == 32'd0) ? 32'd1 : rd_il;
                     fb_ff    <= rd_bank;
                     fs_ff    <= rd_set;
                     st_ff    <= ST_OK;
                     state_ff <= S_D1;
                  end
               end
            end
            S_INS: state_ff <= S_RSP;
            S_D1: if (drsp.done) begin
               t1_ff <= drsp.quotient;      // d / il
               t2_ff <= drsp.remainder;     // d % il
               state_ff <= S_D2;
            end
            S_D2: if (drsp.done) begin
               bank_ff  <= drsp.remainder[11:0];
               state_ff <= S_D3;
            end
            S_D3: if (drsp.done) begin
               t1_ff    <= drsp.quotient;   // d / (il*banks)
               state_ff <= S_D4;
            end
            S_D4: if (drsp.done) begin
               t3_ff    <= drsp.quotient;   // il / line
               prod_ff  <= '0;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               // shift-add: consume one multiplier bit per cycle
               if (t3_ff == '0) begin
                  t3_ff    <= prod_ff;
                  state_ff <= S_D5;
               end else begin
                  if (t3_ff[0]) prod_ff <= prod_ff + t1_ff;
                  t1_ff <= t1_ff << 1;
                  t3_ff <= t3_ff >> 1;
               end
            end
            S_D5: if (drsp.done) begin
               t3_ff    <= t3_ff + drsp.quotient;
               state_ff <= S_D6;
            end
            S_D6: if (drsp.done) begin
               set_ff   <= drsp.remainder[19:0];
               state_ff <= S_RSP;
            end
            S_RSP: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RSP);
   assign rsp_tdata  = {5'd0, set_ff, bank_ff, st_ff};

endmodule

FILE: rtl/core/ribsm_checker.sv
// ----------------------------------------------------------------------------
// Range mapper port checker
// Port-level properties of the mapper, bound to the top level.
// ----------------------------------------------------------------------------
module ribsm_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [39:0]  rsp_tdata
);
   import ribsm_pkg::*;

   // one word in flight: never ready while a result waits
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready during result");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != ST_OK |-> rsp_tdata[34:3] == '0)
      else $error("nonzero payload on failure");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= ST_ZERO_IL) else $error("bad status");

   a_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("ready after accept");

endmodule

bind range_interleaved_bank_set_mapper_unit ribsm_checker u_chk (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);

FILE: sim/range_interleaved_bank_set_mapper_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Range interleaved bank/set mapper testbench
// Builds a range table through insert words and checks every response word
// against a local model of the table, the bank/set arithmetic and the status
// codes, across several mesh/line/set settings and random handshake pacing.
// ----------------------------------------------------------------------------
module range_interleaved_bank_set_mapper_unit_tb;
   import ribsm_pkg::*;

   localparam logic [47:0] ADDR_MASK = {48{1'b1}};
   localparam int          KIND_INSERT = 0;
   localparam int          KIND_LOOKUP = 1;

   typedef struct {
      status_type  status;
      logic [11:0] bank;
      logic [19:0] set_index;
   } mapping_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [159:0]  req_tdata;
   logic          req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [39:0]   rsp_tdata;
   logic          csr_we;
   logic [1:0]    csr_index;
   logic [20:0]   csr_wdata;

   // local copy of the table and the registers
   bit              range_valid [TABLE_ENTRIES];
   longint unsigned range_lo    [TABLE_ENTRIES];
   longint unsigned range_hi    [TABLE_ENTRIES];
   longint unsigned range_il    [TABLE_ENTRIES];
   longint unsigned range_bank  [TABLE_ENTRIES];
   longint unsigned range_set   [TABLE_ENTRIES];
   longint unsigned reg_rows, reg_cols, reg_line, reg_sets;

   mapping_type expected_maps[$];
   int          error_count = 0;
   int          rsp_stall_left = 0;
   int          rsp_taken = 0;
   int          rsp_paced = 0;
   bit          quiet_mode;

   range_interleaved_bank_set_mapper_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("range_interleaved_bank_set_mapper_unit_tb: done, errors");
      $finish;
   end

   function automatic longint unsigned clamp_reg(longint unsigned v, longint unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic longint unsigned rand48();
      longint unsigned v;
      v = {$urandom, $urandom};
      return v & ADDR_MASK;
   endfunction

   // Compute the response of one word and update the table on a good insert.
   function automatic mapping_type predict_mapping(int kind, longint unsigned addr,
         longint unsigned end_addr, longint unsigned il, longint unsigned first_bank,
         longint unsigned first_set);
      mapping_type     m;
      int              free_slot, hit;
      longint unsigned banks, line, sets, d, glob, setnum;
      m.status = ST_OK;
      m.bank = '0;
      m.set_index = '0;
      free_slot = -1;
      hit = -1;
      if (kind == KIND_INSERT) begin
         if (il == 0) begin
            m.status = ST_ZERO_IL;
            return m;
         end
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!range_valid[i]) begin
               if (free_slot < 0) free_slot = i;
            end else if (!(range_lo[i] >= end_addr || range_hi[i] <= addr)) begin
               m.status = ST_OVERLAP;
               return m;
            end
         end
         if (free_slot < 0) begin
            m.status = ST_FULL;
            return m;
         end
         range_valid[free_slot] = 1;
         range_lo[free_slot] = addr;
         range_hi[free_slot] = end_addr;
         range_il[free_slot] = il;
         range_bank[free_slot] = first_bank;
         range_set[free_slot] = first_set;
         return m;
      end
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (hit < 0 && range_valid[i] && range_lo[i] <= addr && addr < range_hi[i])
            hit = i;
      if (hit < 0) begin
         m.status = ST_MISS;
         return m;
      end
      banks = clamp_reg(reg_rows, 64) * clamp_reg(reg_cols, 64);
      line = clamp_reg(reg_line, 4096);
      sets = clamp_reg(reg_sets, 1048576);
      d = addr - range_lo[hit];
      m.bank = 12'((range_bank[hit] + d / range_il[hit]) % banks);
      glob = range_il[hit] * banks;
      setnum = (d / glob) * (range_il[hit] / line) + (d % range_il[hit]) / line;
      m.set_index = 20'((setnum + range_set[hit]) % sets);
      return m;
   endfunction

   task automatic send_word(int kind, longint unsigned addr, longint unsigned end_addr = 0,
         longint unsigned il = 0, longint unsigned first_bank = 0,
         longint unsigned first_set = 0);
      int gap;
      gap = quiet_mode ? 0 : $urandom_range(0, 13);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      addr = addr & ADDR_MASK;
      end_addr = end_addr & ADDR_MASK;
      il = il & 32'hFFFF_FFFF;
      first_bank = first_bank & 12'hFFF;
      first_set = first_set & 20'hFFFFF;
      req_tdata <= {first_set[19:0], first_bank[11:0], il[31:0], end_addr[47:0], addr[47:0]};
      req_tuser <= kind[0];
      req_tvalid <= 1'b1;
      expected_maps.push_back(predict_mapping(kind, addr, end_addr, il, first_bank, first_set));
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_csr(csr_idx_type idx, longint unsigned value);
      @(negedge clock);
      req_tvalid <= 1'b0;
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[20:0];
      case (idx)
         CSR_ROWS: reg_rows = value & 7'h7F;
         CSR_COLS: reg_cols = value & 7'h7F;
         CSR_LINE: reg_line = value & 13'h1FFF;
         default:  reg_sets = value & 21'h1FFFFF;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_maps.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_mesh(longint unsigned rows, longint unsigned cols,
         longint unsigned line, longint unsigned sets);
      wait_drained();
      write_csr(CSR_ROWS, rows);
      write_csr(CSR_COLS, cols);
      write_csr(CSR_LINE, line);
      write_csr(CSR_SETS, sets);
   endtask

   // Check each response word against the oldest expectation.
   always @(posedge clock) begin
      mapping_type exp_map;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_maps.size() == 0) begin
            $error("unexpected response word %h", rsp_tdata);
            error_count++;
         end else begin
            exp_map = expected_maps.pop_front();
            if (rsp_tdata[2:0] !== exp_map.status) begin
               $error("status: expected %0d, actual %0d", exp_map.status, rsp_tdata[2:0]);
               error_count++;
            end
            if (rsp_tdata[14:3] !== exp_map.bank) begin
               $error("bank: expected %0d, actual %0d", exp_map.bank, rsp_tdata[14:3]);
               error_count++;
            end
            if (rsp_tdata[34:15] !== exp_map.set_index) begin
               $error("set_index: expected %0d, actual %0d", exp_map.set_index,
                      rsp_tdata[34:15]);
               error_count++;
            end
         end
         rsp_taken++;
      end
   end

   // draw a new stall after each taken word
   always @(negedge clock) begin
      if (rsp_paced != rsp_taken) begin
         rsp_paced = rsp_taken;
         rsp_stall_left = quiet_mode ? 0 : $urandom_range(0, 13);
      end
      if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic test_directed();
      send_word(KIND_INSERT, 48'h0, 48'h1_0000, 64, 0, 0);
      send_word(KIND_INSERT, 48'hFFFF_0000_0000, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                12'hFFF, 20'hFFFFF);
      // zero interleave wins over overlap
      send_word(KIND_INSERT, 48'h0, 48'h10, 0, 1, 1);
      send_word(KIND_INSERT, 48'h8000, 48'h2_0000, 100, 5, 7);
      // adjacent range is not an overlap
      send_word(KIND_INSERT, 48'h1_0000, 48'h2_0000, 100, 5, 7);
      // empty range takes a slot but holds nothing
      send_word(KIND_INSERT, 48'h5000_0000, 48'h5000_0000, 1, 3, 3);
      send_word(KIND_INSERT, 48'h6000_0000, 48'h5000_0000, 1, 3, 3);
      send_word(KIND_LOOKUP, 48'h0);
      send_word(KIND_LOOKUP, 48'hFFFF);
      send_word(KIND_LOOKUP, 48'h1_0000);
      send_word(KIND_LOOKUP, 48'h1_FFFF);
      send_word(KIND_LOOKUP, 48'h2_0000);
      send_word(KIND_LOOKUP, 48'hFFFF_0000_0000);
      send_word(KIND_LOOKUP, 48'hFFFF_FFFF_FFFE);
      send_word(KIND_LOOKUP, 48'hFFFF_FFFF_FFFF);
      send_word(KIND_LOOKUP, 48'h5000_0000);
      send_word(KIND_LOOKUP, 48'h5800_0000);
      // lookup ignores the insert-only fields
      send_word(KIND_LOOKUP, 48'h40, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 20'hFFFFF);
   endtask

   task automatic test_random_phase(int count);
      int              pick, tries;
      longint unsigned addr, len, il;
      quiet_mode = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 20) quiet_mode = ~quiet_mode;
         if ($urandom_range(0, 4) == 0) begin
            len = rand48() >> $urandom_range(0, 47);
            case ($urandom_range(0, 3))
               0: il = 64'd1 << $urandom_range(0, 31);
               1: il = $urandom_range(1, 4096);
               2: il = $urandom;
               default: il = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 300);
            endcase
            pick = $urandom_range(0, TABLE_ENTRIES - 1);
            addr = (range_valid[pick] && $urandom_range(0, 2) == 0)
                   ? range_lo[pick] + $urandom_range(0, 3) : rand48();
            send_word(KIND_INSERT, addr, addr + len, il, $urandom, $urandom);
         end else begin
            pick = -1;
            tries = 0;
            while (pick < 0 && tries < 8) begin
               tries++;
               pick = $urandom_range(0, TABLE_ENTRIES - 1);
               if (!range_valid[pick] || range_hi[pick] <= range_lo[pick]) pick = -1;
            end
            if (pick < 0 || $urandom_range(0, 9) == 0) begin
               addr = rand48();
            end else begin
               len = range_hi[pick] - range_lo[pick];
               case ($urandom_range(0, 9))
                  0: addr = range_lo[pick];
                  1: addr = range_hi[pick] - 1;
                  2: addr = range_hi[pick];
                  3: addr = range_lo[pick] - 1;
                  default: addr = range_lo[pick] + ({$urandom, $urandom} % len);
               endcase
            end
            send_word(KIND_LOOKUP, addr, rand48(), $urandom, $urandom, $urandom);
         end
      end
   endtask

   initial begin
      quiet_mode = 0;
      reg_rows = 8;
      reg_cols = 8;
      reg_line = 64;
      reg_sets = 1024;
      foreach (range_valid[i]) range_valid[i] = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_ROWS;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_phase(250);
      set_mesh(1, 1, 1, 1);
      test_random_phase(250);
      set_mesh(64, 64, 4096, 1048576);
      test_random_phase(250);
      set_mesh(0, 0, 0, 0);
      test_random_phase(250);
      set_mesh(127, 127, 8191, 21'h1FFFFF);
      test_random_phase(250);
      set_mesh(3, 5, 48, 1000);
      test_random_phase(300);
      set_mesh(16, 4, 128, 4096);
      test_random_phase(330);

      wait_drained();
      if (error_count == 0)
         $display("range_interleaved_bank_set_mapper_unit_tb: done, clean");
      else
         $display("range_interleaved_bank_set_mapper_unit_tb: done, errors");
      $finish;
   end

endmodule
